@@ hdl/mdcc_pkg.sv @@
package mdcc_pkg;

    // default sizes, handed down from the top level
    localparam int MAX_CODE_SYMBOLS_DEF = 64;
    localparam int SET_ENTRIES_DEF      = 128;

    // fixed field widths
    localparam int LETTER_W = 5;
    localparam int COUNT_W  = 8;
    localparam int SYM_N_W  = 3;
    localparam int SYM_B_W  = 4;
    localparam int LETTERS  = 26;

    // morse table, dot = 0, dash = 1, first symbol in the highest of len bits
    localparam logic [SYM_B_W-1:0] MORSE_BITS [LETTERS] = '{
        4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
        4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
    };
    localparam logic [SYM_N_W-1:0] MORSE_LEN [LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    // symbol count of a letter, zero for codes past z
    function automatic logic [SYM_N_W-1:0] morse_len(input logic [LETTER_W-1:0] letter);
        logic [SYM_N_W-1:0] len;
        len = '0;
        if (letter < LETTER_W'(LETTERS)) begin
            len = MORSE_LEN[letter];
        end
        return len;
    endfunction

    // symbol bits of a letter, zero for codes past z
    function automatic logic [SYM_B_W-1:0] morse_bits(input logic [LETTER_W-1:0] letter);
        logic [SYM_B_W-1:0] bits;
        bits = '0;
        if (letter < LETTER_W'(LETTERS)) begin
            bits = MORSE_BITS[letter];
        end
        return bits;
    endfunction

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic list_pend;
        logic out_full;
    } t_dp_status;

endpackage

@@ hdl/mdcc_ctrl.sv @@
module mdcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_word_end,
    input  logic                i_list_end,
    input  mdcc_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output mdcc_pkg::t_dp_cmd   o_cmd
);

    mdcc_pkg::t_state r_state;
    mdcc_pkg::t_state n_state;
    logic             done;
    logic             blocked;

    // search finished, and whether a list end must wait for the occupied result register
    assign done    = i_status.hit || i_status.miss;
    assign blocked = i_status.list_pend && i_status.out_full;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mdcc_pkg::ST_IDLE: begin
                if (i_in_valid && (i_word_end || i_list_end)) begin
                    n_state = mdcc_pkg::ST_SCAN;
                end
            end
            mdcc_pkg::ST_SCAN: begin
                if (done && !blocked) begin
                    n_state = mdcc_pkg::ST_IDLE;
                end
            end
            default: n_state = mdcc_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            mdcc_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.accept     = i_in_valid;
                o_cmd.scan_start = i_in_valid && (i_word_end || i_list_end);
            end
            mdcc_pkg::ST_SCAN: begin
                o_cmd.scan_step = !done;
                o_cmd.finish    = done && !blocked;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/mdcc_datapath.sv @@
module mdcc_datapath #(
    parameter int MAX_CODE_SYMBOLS = mdcc_pkg::MAX_CODE_SYMBOLS_DEF,
    parameter int SET_ENTRIES      = mdcc_pkg::SET_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mdcc_pkg::t_dp_cmd            i_cmd,
    input  logic [mdcc_pkg::LETTER_W-1:0] i_letter,
    input  logic                         i_list_end,
    input  logic                         i_out_ready,
    output mdcc_pkg::t_dp_status         o_status,
    output logic                         o_out_valid,
    output logic [mdcc_pkg::COUNT_W-1:0] o_out_count,
    output logic                         o_out_ovf
);

    localparam int SW = MAX_CODE_SYMBOLS;
    localparam int LW = $clog2(MAX_CODE_SYMBOLS + 1);
    localparam int AW = $clog2(SET_ENTRIES);
    localparam int CW = $clog2(SET_ENTRIES + 2);
    localparam int EW = SW + LW;

    logic [SW-1:0] r_code;
    logic [LW-1:0] r_len;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_pend_list;
    logic [CW-1:0] r_scan_addr;
    logic          r_primed;
    logic          r_live;
    logic [EW-1:0] r_rd_data;
    logic          r_out_valid;
    logic [mdcc_pkg::COUNT_W-1:0] r_out_count;
    logic          r_out_ovf;

    logic [EW-1:0] mem [SET_ENTRIES];

    logic [mdcc_pkg::SYM_N_W-1:0] sym_n;
    logic [mdcc_pkg::SYM_B_W-1:0] sym_b;
    logic [LW-1:0]                room;
    logic [mdcc_pkg::SYM_N_W-1:0] take;
    logic [SW-1:0] n_code;
    logic [LW-1:0] n_len;
    logic          app_ovf;
    logic          hit;
    logic          miss;
    logic          has_room;
    logic [CW-1:0] n_count;
    logic          n_ovf;

    // append one letter, dropping symbols past the code word capacity
    always_comb begin
        sym_n   = mdcc_pkg::morse_len(i_letter);
        sym_b   = mdcc_pkg::morse_bits(i_letter);
        room    = LW'(MAX_CODE_SYMBOLS) - r_len;
        app_ovf = LW'(sym_n) > room;
        take    = app_ovf ? room[mdcc_pkg::SYM_N_W-1:0] : sym_n;
        n_code  = (r_code << take) | SW'(sym_b >> (sym_n - take));
        n_len   = r_len + LW'(take);
    end

    // search result and set update at the end of a word
    always_comb begin
        hit      = r_primed && r_live && (r_rd_data == {r_len, r_code});
        miss     = r_primed && !r_live;
        has_room = r_count < CW'(SET_ENTRIES);
        n_count  = (miss && has_room) ? r_count + CW'(1) : r_count;
        n_ovf    = r_ovf || (miss && !has_room);
    end

    // control and code word registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code      <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_pend_list <= 1'b0;
            r_scan_addr <= '0;
            r_primed    <= 1'b0;
            r_live      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_code      <= n_code;
                r_len       <= n_len;
                r_pend_list <= i_list_end;
                if (app_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.scan_start) begin
                r_scan_addr <= '0;
                r_primed    <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_scan_addr <= r_scan_addr + CW'(1);
                r_primed    <= 1'b1;
                r_live      <= r_scan_addr < r_count;
            end
            if (i_cmd.finish) begin
                r_code   <= '0;
                r_len    <= '0;
                r_primed <= 1'b0;
                r_count  <= r_pend_list ? '0 : n_count;
                r_ovf    <= r_pend_list ? 1'b0 : n_ovf;
            end
            // result register
            if (i_cmd.finish && r_pend_list) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, count saturates at the field's top
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && r_pend_list) begin
            r_out_count <= (32'(n_count) > 32'd255) ? '1 : mdcc_pkg::COUNT_W'(n_count);
            r_out_ovf   <= n_ovf;
        end
    end

    // set store, one read port for the scan, one write port for inserts
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && miss && has_room) begin
            mem[r_count[AW-1:0]] <= {r_len, r_code};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= mem[r_scan_addr[AW-1:0]];
        end
    end

    assign o_status.hit       = hit;
    assign o_status.miss      = miss;
    assign o_status.list_pend = r_pend_list;
    assign o_status.out_full  = r_out_valid;
    assign o_out_valid        = r_out_valid;
    assign o_out_count        = r_out_count;
    assign o_out_ovf          = r_out_ovf;

    // set never holds more than its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SET_ENTRIES))
        else $error("set entry count past capacity");

    // code word never longer than its capacity
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_CODE_SYMBOLS))
        else $error("code word length past capacity");

    // scan stops at the first address past the stored entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> r_scan_addr <= r_count)
        else $error("scan ran past stored entries");

    // list end leaves an empty set and a clear overflow
    a_list_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_pend_list |=> r_count == '0 && !r_ovf && r_out_valid)
        else $error("list end did not clear the set");

endmodule

@@ hdl/morse_distinct_code_counter_core.sv @@
// Morse distinct code counter.
// Input stream s_axis: one letter per request, tdata[4:0] = letter (0 = a),
// tuser = last letter of a word, tlast = last letter of the list (also ends
// the word). Output stream m_axis: one request per list, tdata = number of
// distinct code words (saturates at 255), tuser = overflow flag.
// A letter that does not end a word is only appended to the code word. A
// word end is appended too and then starts a scan of the set store, one
// stored entry per cycle through its single read port, until a match or
// the first address past the entries stored so far; no letter is taken meanwhile.
// A list end delivers its result into the output register at the end of
// that scan; the result is visible on m_axis the cycle after.
// The output register holds one result; letters keep being taken while it
// waits, and only a following list end stalls until it has been taken.
// Reset (synchronous, active low) empties the set, clears the code word and
// overflow, and drops any pending result. The set store needs no clearing
// pass: only entries below the fill count are ever compared.
module morse_distinct_code_counter_core #(
    parameter int MAX_CODE_SYMBOLS = mdcc_pkg::MAX_CODE_SYMBOLS_DEF,
    parameter int SET_ENTRIES      = mdcc_pkg::SET_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter_index, [7:5] zero
    input  logic       s_axis_tuser,   // [0] word_end
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] distinct_count
    output logic       m_axis_tuser    // [0] overflow_flag
);

    mdcc_pkg::t_dp_cmd    cmd;
    mdcc_pkg::t_dp_status status;

    // sequencer
    mdcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_word_end (s_axis_tuser),
        .i_list_end (s_axis_tlast),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // code word, set store and result register
    mdcc_datapath #(
        .MAX_CODE_SYMBOLS (MAX_CODE_SYMBOLS),
        .SET_ENTRIES      (SET_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_letter    (s_axis_tdata[mdcc_pkg::LETTER_W-1:0]),
        .i_list_end  (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_count (m_axis_tdata),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

@@ test/morse_distinct_code_counter_core_test.sv @@
`timescale 1ns / 100ps

module morse_distinct_code_counter_core_test;

    localparam int CODE_MAX     = mdcc_pkg::MAX_CODE_SYMBOLS_DEF;
    localparam int SET_MAX      = mdcc_pkg::SET_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX   = 10;

    // letter codes used by name below
    localparam logic [4:0] LT_A      = 5'd0;
    localparam logic [4:0] LT_E      = 5'd4;
    localparam logic [4:0] LT_H      = 5'd7;
    localparam logic [4:0] LT_I      = 5'd8;
    localparam logic [4:0] LT_T      = 5'd19;
    localparam logic [4:0] LT_Z      = 5'd25;
    localparam logic [4:0] LT_OOR_LO = 5'd26;
    localparam logic [4:0] LT_OOR_HI = 5'd31;

    // morse symbols per letter, dot = 0, dash = 1, first symbol highest
    localparam logic [3:0] DIT_DAH [26] = '{
        4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
        4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
    };
    localparam int SYM_COUNT [26] = '{
        2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2,
        2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4
    };

    typedef struct packed {
        logic [7:0] count;
        logic       ovf;
    } t_tally;

    typedef struct {
        logic [4:0] letter;
        bit         wend;
        bit         lend;
        bit         typed;
        t_tally     want;
    } t_letter_row;

    typedef enum int {
        LIST_SHORT,
        LIST_DUPES,
        LIST_LONG,
        LIST_FULL
    } t_list_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [4:0] letter_index, [7:5] zero
    logic       s_axis_tuser;   // [0] word_end
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] distinct_count
    logic       m_axis_tuser;   // [0] overflow_flag

    // predicted state of the code word and the set
    logic [63:0] code_word;
    int          code_len;
    logic [63:0] set_word [SET_MAX];
    int          set_len [SET_MAX];
    int          set_fill;
    bit          overflow_hit;

    t_tally      tally_due_q [$];
    t_letter_row directed_rows [$];
    int          errors = 0;
    int          items_sent;
    int          idle_cycles;
    bit          no_gaps;

    morse_distinct_code_counter_core #(
        .MAX_CODE_SYMBOLS (CODE_MAX),
        .SET_ENTRIES      (SET_MAX)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // append one letter, close the word on a flag, tally the list on its end
    task automatic tally_letter(input logic [4:0] letter, input bit wend, input bit lend,
                                output bit done, output t_tally res);
        bit found;
        found = 1'b0;
        done  = 1'b0;
        res   = '0;
        if (letter < 5'd26) begin
            for (int k = SYM_COUNT[letter]; k > 0; k--) begin
                if (code_len < CODE_MAX) begin
                    code_word = {code_word[62:0], DIT_DAH[letter][k-1]};
                    code_len++;
                end else begin
                    overflow_hit = 1'b1;
                end
            end
        end
        if (wend || lend) begin
            for (int k = 0; k < set_fill; k++) begin
                if (set_word[k] == code_word && set_len[k] == code_len) begin
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (set_fill < SET_MAX) begin
                    set_word[set_fill] = code_word;
                    set_len[set_fill]  = code_len;
                    set_fill++;
                end else begin
                    overflow_hit = 1'b1;
                end
            end
            code_word = '0;
            code_len  = 0;
        end
        if (lend) begin
            done         = 1'b1;
            res.count    = (set_fill > 255) ? 8'd255 : 8'(set_fill);
            res.ovf      = overflow_hit;
            set_fill     = 0;
            overflow_hit = 1'b0;
        end
    endtask

    // one letter request on the input stream, predicted once accepted
    task automatic send_letter(input logic [4:0] letter, input bit wend, input bit lend,
                               input bit typed, input t_tally want);
        int     gap;
        bit     done;
        t_tally res;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b000, letter};
        s_axis_tuser  = wend;
        s_axis_tlast  = lend;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        tally_letter(letter, wend, lend, done, res);
        if (done) begin
            tally_due_q.push_back(typed ? want : res);
        end
    endtask

    // hold the input stream until every pending tally has come out
    task automatic wait_for_tallies();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tally_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [4:0] letter, input bit wend, input bit lend,
                           input bit typed, input int count, input bit ovf);
        t_letter_row row;
        row.letter     = letter;
        row.wend       = wend;
        row.lend       = lend;
        row.typed      = typed;
        row.want.count = 8'(count);
        row.want.ovf   = ovf;
        directed_rows.push_back(row);
    endtask

    function automatic logic [4:0] pick_letter(input t_list_kind kind);
        logic [4:0] dupes [4];
        dupes = '{LT_E, LT_T, LT_A, LT_I};
        if ($urandom_range(0, 11) == 0) begin
            return 5'($urandom_range(LT_OOR_LO, LT_OOR_HI));
        end
        if (kind == LIST_DUPES) begin
            return dupes[$urandom_range(0, 3)];
        end
        return 5'($urandom_range(0, 25));
    endfunction

    // one random list of words, the last letter ends the list
    task automatic send_list(input t_list_kind kind);
        int         n_words;
        int         n_letters;
        bit         last;
        bit         lend;
        logic [4:0] letter;
        case (kind)
            LIST_FULL: n_words = $urandom_range(SET_MAX + 4, SET_MAX + 20);
            LIST_LONG: n_words = $urandom_range(1, 3);
            default:   n_words = $urandom_range(1, 8);
        endcase
        for (int w = 0; w < n_words; w++) begin
            case (kind)
                LIST_FULL: n_letters = 3;
                LIST_LONG: n_letters = $urandom_range(14, 24);
                default:   n_letters = $urandom_range(1, 5);
            endcase
            for (int l = 0; l < n_letters; l++) begin
                letter = pick_letter(kind);
                last   = (l == n_letters - 1);
                lend   = last && (w == n_words - 1);
                send_letter(letter, lend ? bit'($urandom_range(0, 1)) : last, lend,
                            1'b0, '0);
            end
        end
    endtask

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        errors++;
        if (errors <= REPORT_MAX) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // result side: random stalls, compare against the oldest tally
    initial begin
        int     stall;
        t_tally want;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (tally_due_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("unexpected result: count %0d, overflow %0b",
                             m_axis_tdata, m_axis_tuser);
                end
            end else begin
                want = tally_due_q.pop_front();
                if (m_axis_tdata !== want.count) begin
                    report_mismatch("distinct_count", want.count, m_axis_tdata);
                end
                if (m_axis_tuser !== want.ovf) begin
                    report_mismatch("overflow_flag", want.ovf, m_axis_tuser);
                end
            end
        end
    end

    // stimulus
    initial begin
        t_list_kind kind;
        int         r;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        code_word     = '0;
        code_len      = 0;
        set_fill      = 0;
        overflow_hit  = 1'b0;
        items_sent    = 0;
        no_gaps       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single letter list right after reset
        add_row(LT_A, 1'b0, 1'b1, 1'b1, 1, 1'b0);
        // empty code word from the highest out-of-range letter
        add_row(LT_OOR_HI, 1'b0, 1'b1, 1'b1, 1, 1'b0);
        // "et" spells the same code as "a", list end without word end
        add_row(LT_E, 1'b0, 1'b0, 1'b0, 0, 1'b0);
        add_row(LT_T, 1'b1, 1'b0, 1'b0, 0, 1'b0);
        add_row(LT_A, 1'b0, 1'b1, 1'b1, 1, 1'b0);
        // last letter, an empty word, and the last letter again
        add_row(LT_Z, 1'b1, 1'b0, 1'b0, 0, 1'b0);
        add_row(LT_OOR_LO, 1'b1, 1'b0, 1'b0, 0, 1'b0);
        add_row(LT_Z, 1'b1, 1'b1, 1'b1, 2, 1'b0);
        // sixteen h fill the code word, one more dot overflows it
        for (int k = 0; k < 16; k++) begin
            add_row(LT_H, 1'b0, 1'b0, 1'b0, 0, 1'b0);
        end
        add_row(LT_E, 1'b0, 1'b1, 1'b1, 1, 1'b1);

        foreach (directed_rows[k]) begin
            send_letter(directed_rows[k].letter, directed_rows[k].wend,
                        directed_rows[k].lend, directed_rows[k].typed,
                        directed_rows[k].want);
        end
        wait_for_tallies();

        // random lists, the first with more words than the set holds
        send_list(LIST_FULL);
        while (items_sent < RANDOM_ITEMS + directed_rows.size()) begin
            if ($urandom_range(0, 3) == 0) begin
                no_gaps = ~no_gaps;
            end
            r = $urandom_range(0, 49);
            if (r == 0) begin
                kind = LIST_FULL;
            end else if (r < 6) begin
                kind = LIST_LONG;
            end else if (r < 26) begin
                kind = LIST_DUPES;
            end else begin
                kind = LIST_SHORT;
            end
            send_list(kind);
            if ($urandom_range(0, 9) == 0) begin
                wait_for_tallies();
            end
        end

        // drain
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tally_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && tally_due_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/mdcc_pkg.sv
hdl/mdcc_ctrl.sv
hdl/mdcc_datapath.sv
hdl/morse_distinct_code_counter_core.sv
test/morse_distinct_code_counter_core_test.sv
